@@ design/vbt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vbt_pkg
// Shared types and constants for the vertex basis transform core.
// ----------------------------------------------------------------------------
package vbt_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF  = 16;
  localparam int COEF_FRAC       = 12;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_IDX_W       = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFTX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFTY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFTZ = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd6;

  // per-item work decided at the front
  typedef struct packed {
    logic rotate;
    logic translate;
  } op_t;

endpackage
`default_nettype wire

@@ design/vbt_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vbt_front
// Input stage: takes one point per transfer and classifies it into the
// operation the back pipeline carries out.
// ----------------------------------------------------------------------------
module vbt_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rotate_mode_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [2:0][COORD_WIDTH-1:0]    coord_i,
  output logic                           push_o,
  input  logic                           q_full_i,
  output vbt_pkg::op_t                   op_o,
  output logic [2:0][COORD_WIDTH-1:0]    coord_o
);
  import vbt_pkg::*;

  logic                        valid_q, valid_d;
  op_t                         op_q;
  logic [2:0][COORD_WIDTH-1:0] coord_q;
  logic                        accept;

  assign push_o     = valid_q && !q_full_i;
  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // normals skip translation, translate-only normals pass through
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q.rotate    <= rotate_mode_i;
      op_q.translate <= !kind_i;
      coord_q        <= coord_i;
    end
  end

  assign op_o    = op_q;
  assign coord_o = coord_q;

endmodule
`default_nettype wire

@@ design/vbt_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vbt_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module vbt_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  import vbt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");
  a_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a push");

endmodule
`default_nettype wire

@@ design/vbt_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vbt_back
// Execution pipeline: multiply, sum and round, translate and saturate.
// ----------------------------------------------------------------------------
module vbt_back #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [2:0][3*COEF_WIDTH-1:0]   mat_i,
  input  logic [2:0][COORD_WIDTH-1:0]    shift_i,
  input  logic                           q_valid_i,
  output logic                           pop_o,
  input  vbt_pkg::op_t                   q_op_i,
  input  logic [2:0][COORD_WIDTH-1:0]    q_coord_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0][COORD_WIDTH-1:0]    out_coord_o,
  output logic                           overflow_o
);
  import vbt_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int KW = COEF_WIDTH;
  localparam int PW = CW + KW;
  localparam int SW = PW + 2;
  localparam int WW = SW + 1;
  localparam logic signed [SW-1:0] RND = SW'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [WW-1:0] SAT_HI = {{(WW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [WW-1:0] SAT_LO = ~SAT_HI;

  logic advance;

  logic                          s1_valid_q, s2_valid_q, s3_valid_q;
  op_t                           s1_op_q;
  logic                          s2_trans_q;
  logic signed [PW-1:0]          prod_q [3][3];
  logic signed [PW-1:0]          prod_d [3][3];
  logic signed [SW-1:0]          val_q  [3];
  logic signed [SW-1:0]          val_d  [3];
  logic [2:0][CW-1:0]            res_q, res_d;
  logic                          ovf_q, ovf_d;

  assign advance = !(s3_valid_q && out_stall_i);
  assign pop_o   = advance && q_valid_i;

  // stage one: nine products, or the raw coordinate when not rotating
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (q_op_i.rotate) begin
          prod_d[r][c] = $signed(mat_i[r][c*KW +: KW]) * $signed(q_coord_i[c]);
        end else if (c == 0) begin
          prod_d[r][c] = PW'($signed(q_coord_i[r]));
        end else begin
          prod_d[r][c] = '0;
        end
      end
    end
  end

  // stage two: row sums, rounded and scaled, or the raw coordinate when not rotating
  always_comb begin
    logic signed [SW-1:0] sum;
    for (int r = 0; r < 3; r++) begin
      sum = SW'(prod_q[r][0]) + SW'(prod_q[r][1]) + SW'(prod_q[r][2]) + RND;
      if (s1_op_q.rotate) begin
        val_d[r] = sum >>> COEF_FRAC;
      end else begin
        val_d[r] = SW'(prod_q[r][0]);
      end
    end
  end

  // stage three: translation and saturation
  always_comb begin
    logic signed [WW-1:0] tot;
    ovf_d = 1'b0;
    for (int r = 0; r < 3; r++) begin
      tot = WW'(val_q[r]);
      if (s2_trans_q) begin
        tot = tot + WW'($signed(shift_i[r]));
      end
      if (tot > SAT_HI) begin
        res_d[r] = SAT_HI[CW-1:0];
        ovf_d    = 1'b1;
      end else if (tot < SAT_LO) begin
        res_d[r] = SAT_LO[CW-1:0];
        ovf_d    = 1'b1;
      end else begin
        res_d[r] = tot[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= q_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_op_q    <= q_op_i;
      prod_q     <= prod_d;
      s2_trans_q <= s1_op_q.translate;
      val_q      <= val_d;
      res_q      <= res_d;
      ovf_q      <= ovf_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_coord_o = res_q;
  assign overflow_o  = ovf_q;

  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");
  a_no_pop_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !pop_o)
    else $error("queue popped while pipeline stalled");
  a_pull_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_i && !out_valid_o) |-> pop_o)
    else $error("pipeline idle with queued item");

endmodule
`default_nettype wire

@@ design/vertex_basis_transform_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_basis_transform_core
// 3x3 matrix transform with translation for vertices and normals.
// ----------------------------------------------------------------------------
// Accepts one point per clock and delivers one result per clock while the
// output is not stalled. Each result is registered through the input
// register, the queue, and the three-stage back pipeline (products,
// rounded row sums, translation with saturation). Configuration registers
// are written through the plain write port. The user must write them only
// while no item is in flight; the block does not enforce this. Writes to
// index seven are ignored. rotate_mode resets to one, all others to zero.
// ----------------------------------------------------------------------------
module vertex_basis_transform_core #(
  parameter int COORD_WIDTH = vbt_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = vbt_pkg::COEF_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [vbt_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [((3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH)-1:0]
                                                 cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   kind_i,
  input  logic signed [COORD_WIDTH-1:0]          in_x_i,
  input  logic signed [COORD_WIDTH-1:0]          in_y_i,
  input  logic signed [COORD_WIDTH-1:0]          in_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [COORD_WIDTH-1:0]          out_x_o,
  output logic signed [COORD_WIDTH-1:0]          out_y_o,
  output logic signed [COORD_WIDTH-1:0]          out_z_o,
  output logic                                   overflow_o
);
  import vbt_pkg::*;

  localparam int RW = 3 * COEF_WIDTH;
  localparam int QW = $bits(op_t) + 3 * COORD_WIDTH;

  logic [2:0][RW-1:0]          mat_q;
  logic [2:0][COORD_WIDTH-1:0] shift_q;
  logic                        rotate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q    <= '0;
      shift_q  <= '0;
      rotate_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROW0:   mat_q[0]   <= cfg_data_i[RW-1:0];
        REG_ROW1:   mat_q[1]   <= cfg_data_i[RW-1:0];
        REG_ROW2:   mat_q[2]   <= cfg_data_i[RW-1:0];
        REG_SHIFTX: shift_q[0] <= cfg_data_i[COORD_WIDTH-1:0];
        REG_SHIFTY: shift_q[1] <= cfg_data_i[COORD_WIDTH-1:0];
        REG_SHIFTZ: shift_q[2] <= cfg_data_i[COORD_WIDTH-1:0];
        REG_MODE:   rotate_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic                        push, q_full, q_valid, pop;
  op_t                         f_op, q_op;
  logic [2:0][COORD_WIDTH-1:0] f_coord, q_coord, out_coord;
  logic [QW-1:0]               q_wdata, q_rdata;

  vbt_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rotate_mode_i (rotate_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .coord_i       ({in_z_i, in_y_i, in_x_i}),
    .push_o        (push),
    .q_full_i      (q_full),
    .op_o          (f_op),
    .coord_o       (f_coord)
  );

  assign q_wdata = {f_op, f_coord};

  vbt_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  assign {q_op, q_coord} = q_rdata;

  vbt_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mat_i       (mat_q),
    .shift_i     (shift_q),
    .q_valid_i   (q_valid),
    .pop_o       (pop),
    .q_op_i      (q_op),
    .q_coord_i   (q_coord),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_coord_o (out_coord),
    .overflow_o  (overflow_o)
  );

  assign out_x_o = out_coord[0];
  assign out_y_o = out_coord[1];
  assign out_z_o = out_coord[2];

endmodule
`default_nettype wire
